@@ src/pts_pkg.sv @@
// Shared types and constants for the periodic task scheduler.
// Depends on nothing; every other file imports it.
`default_nettype none

package pts_pkg;

  // Table size and pointer widths; a pointer equal to Nil marks an empty link
  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned IdxW      = $clog2(MAX_TASKS);
  localparam int unsigned PtrW      = $clog2(MAX_TASKS + 1);
  localparam int unsigned TimeW     = 32;
  localparam logic [PtrW-1:0] Nil   = PtrW'(MAX_TASKS);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [PtrW-1:0] ptr_t;

  typedef enum logic [1:0] {
    ACT_REGISTER   = 2'd0,
    ACT_UNREGISTER = 2'd1,
    ACT_POLL       = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [3:0]       task_slot;
    logic [TimeW-1:0] interval_ms;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       due_valid;
    logic [3:0] due_task;
    logic       last_of_run;
  } out_item_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FIND   = 5'b00010,
    ST_UNLINK = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_e;

  // Address select for the link table read port
  typedef enum logic [1:0] {
    RD_IN_SLOT = 2'd0,
    RD_CUR     = 2'd1,
    RD_SLOT_Q  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    capture;
    logic    do_reg;
    logic    unlink_head;
    logic    do_clear;
    logic    start_walk;
    logic    step;
    logic    mark_due;
    logic    do_unlink;
    logic    emit;
    logic    emit_status;
    logic    emit_due;
    logic    emit_last;
    rd_sel_e rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic reg_ok;
    logic slot_listed;
    logic head_nil;
    logic head_is_slot;
    logic due;
    logic cur_is_tail;
    logic next_is_slot;
    logic pend_valid;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ src/pts_datapath.sv @@
// Slot tables, list pointers, walk cursor and result register.
// Depends on pts_pkg; driven by pts_controller commands.
`default_nettype none

module pts_datapath import pts_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_data_i,
  input  wire dp_cmd_t   cmd_i,
  output dp_sts_t        sts_o,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output out_item_t      out_data_o
);

  logic [MAX_TASKS-1:0] listed_q, listed_d;
  logic [TimeW-1:0]     period_q [MAX_TASKS];
  logic [TimeW-1:0]     last_q   [MAX_TASKS];
  ptr_t                 next_q   [MAX_TASKS];
  ptr_t                 head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic                 pend_valid_q, pend_valid_d;
  idx_t                 pend_task_q;
  idx_t                 slot_q;
  logic [TimeW-1:0]     now_q;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q;

  idx_t             in_slot, cur_idx, tail_idx, rd_idx;
  ptr_t             in_ptr, slot_ptr, next_rd;
  logic             slot_ok, out_free;
  logic [TimeW-1:0] elapsed;

  assign in_slot  = IdxW'(in_data_i.task_slot);
  assign in_ptr   = PtrW'(in_data_i.task_slot);
  assign slot_ptr = PtrW'(slot_q);
  assign cur_idx  = cur_q[IdxW-1:0];
  assign tail_idx = tail_q[IdxW-1:0];
  assign slot_ok  = in_ptr < Nil;
  assign out_free = !out_valid_q || !out_stall_i;

  // Select the link table read address
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IN_SLOT: rd_idx = in_slot;
      RD_CUR:     rd_idx = cur_idx;
      RD_SLOT_Q:  rd_idx = slot_q;
      default:    rd_idx = cur_idx;
    endcase
  end
  assign next_rd = next_q[rd_idx];

  // Wrap-safe elapsed time of the slot under the cursor
  assign elapsed = now_q - last_q[cur_idx];

  // Report status to the controller
  always_comb begin
    sts_o.reg_ok       = slot_ok && (in_data_i.interval_ms != '0) && !listed_q[in_slot];
    sts_o.slot_listed  = slot_ok && listed_q[in_slot];
    sts_o.head_nil     = head_q == Nil;
    sts_o.head_is_slot = head_q == in_ptr;
    sts_o.due          = elapsed >= period_q[cur_idx];
    sts_o.cur_is_tail  = cur_q == tail_q;
    sts_o.next_is_slot = next_rd == slot_ptr;
    sts_o.pend_valid   = pend_valid_q;
    sts_o.out_free     = out_free;
  end

  // Update list pointers, listed bits and the walk cursor
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    cur_d        = cur_q;
    listed_d     = listed_q;
    pend_valid_d = pend_valid_q;
    if (cmd_i.do_reg) begin
      listed_d[in_slot] = 1'b1;
      if (head_q == Nil) begin
        head_d = in_ptr;
      end
      tail_d = in_ptr;
    end
    if (cmd_i.unlink_head) begin
      listed_d[in_slot] = 1'b0;
      if (tail_q == in_ptr) begin
        head_d = Nil;
        tail_d = Nil;
      end else begin
        head_d = next_rd;
      end
    end
    if (cmd_i.do_clear) begin
      listed_d = '0;
      head_d   = Nil;
      tail_d   = Nil;
    end
    if (cmd_i.start_walk) begin
      cur_d        = head_q;
      pend_valid_d = 1'b0;
    end
    if (cmd_i.step) begin
      cur_d = next_rd;
    end
    if (cmd_i.mark_due) begin
      pend_valid_d = 1'b1;
    end
    if (cmd_i.do_unlink) begin
      listed_d[slot_q] = 1'b0;
      if (tail_q == slot_ptr) begin
        tail_d = cur_q;
      end
    end
  end

  // Hold the result until taken; load a new one on emit
  always_comb begin
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listed_q     <= '0;
      head_q       <= Nil;
      tail_q       <= Nil;
      cur_q        <= Nil;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      listed_q     <= listed_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      cur_q        <= cur_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Slot tables and item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q <= in_slot;
      now_q  <= in_data_i.now_ms;
    end
    if (cmd_i.do_reg) begin
      period_q[in_slot] <= in_data_i.interval_ms;
      last_q[in_slot]   <= in_data_i.now_ms;
      if (head_q != Nil) begin
        next_q[tail_idx] <= in_ptr;
      end
    end else if (cmd_i.mark_due) begin
      last_q[cur_idx] <= now_q;
    end
    if (cmd_i.do_unlink) begin
      next_q[cur_idx] <= next_rd;
    end
    if (cmd_i.mark_due) begin
      pend_task_q <= cur_idx;
    end
    if (cmd_i.emit) begin
      out_q.status      <= cmd_i.emit_status;
      out_q.due_valid   <= cmd_i.emit_due;
      out_q.due_task    <= cmd_i.emit_due ? 4'(pend_task_q) : 4'd0;
      out_q.last_of_run <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // List pointers stay consistent
  a_head_tail_nil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == Nil) == (tail_q == Nil))
    else $error("head and tail disagree on an empty list");

  a_head_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != Nil) |-> listed_q[head_q[IdxW-1:0]])
    else $error("list head is not a listed slot");

  a_tail_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q != Nil) |-> listed_q[tail_idx])
    else $error("list tail is not a listed slot");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result emitted over a held result");

endmodule

`default_nettype wire

@@ src/pts_controller.sv @@
// Sequencer for register, unregister, poll and clear actions.
// Depends on pts_pkg; drives pts_datapath through dp_cmd_t.
`default_nettype none

module pts_controller import pts_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire action_e in_action_i,
  output logic         in_stall_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  // Take an item only when idle and the result register has room
  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = RD_CUR;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.rd_sel = RD_IN_SLOT;
        if (accept) begin
          cmd_o.capture = 1'b1;
          unique case (in_action_i)
            ACT_REGISTER: begin
              cmd_o.do_reg      = sts_i.reg_ok;
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = !sts_i.reg_ok;
              cmd_o.emit_last   = 1'b1;
            end
            ACT_UNREGISTER: begin
              if (!sts_i.slot_listed) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = 1'b1;
                cmd_o.emit_last   = 1'b1;
              end else if (sts_i.head_is_slot) begin
                cmd_o.unlink_head = 1'b1;
                cmd_o.emit        = 1'b1;
                cmd_o.emit_last   = 1'b1;
              end else begin
                // search for the predecessor from the head
                cmd_o.start_walk = 1'b1;
                state_d          = ST_FIND;
              end
            end
            ACT_POLL: begin
              if (sts_i.head_nil) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_last = 1'b1;
              end else begin
                cmd_o.start_walk = 1'b1;
                state_d          = ST_WALK;
              end
            end
            ACT_CLEAR: begin
              cmd_o.do_clear  = 1'b1;
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
            end
            default: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
            end
          endcase
        end
      end
      ST_FIND: begin
        // advance until the next link names the slot
        if (sts_i.next_is_slot) begin
          state_d = ST_UNLINK;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_UNLINK: begin
        cmd_o.rd_sel = RD_SLOT_Q;
        if (sts_i.out_free) begin
          cmd_o.do_unlink = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_WALK: begin
        // hold when a due slot must push out a pending one that has no room
        if (!(sts_i.due && sts_i.pend_valid && !sts_i.out_free)) begin
          if (sts_i.due) begin
            cmd_o.mark_due = 1'b1;
            if (sts_i.pend_valid) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_due = 1'b1;
            end
          end
          if (sts_i.cur_is_tail) begin
            state_d = ST_FLUSH;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        // close the run with the last due slot or a no-hit result
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_due  = sts_i.pend_valid;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

  a_flush_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && sts_i.out_free) |-> (cmd_o.emit && cmd_o.emit_last))
    else $error("poll finished without a closing result");

  a_walk_step_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.step && cmd_o.do_unlink))
    else $error("cursor advance during unlink");

endmodule

`default_nettype wire

@@ src/periodic_task_scheduler_unit.sv @@
// Periodic task scheduler: register, unregister, poll and clear of 16 slots.
// Register, clear, refused unregister, head unregister and an empty poll give their
//   single result in the cycle after the item is accepted.
// Walks: a poll walks the list one listed slot per cycle unless a due slot waits
//   for room for a pending result; an unregister walks to the predecessor.
// Reset: list empty, no item in flight; slot tables are left undefined until written.
// Depends on pts_pkg, pts_controller and pts_datapath.
`default_nettype none

module periodic_task_scheduler_unit import pts_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pts_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pts_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
